/* hdl/bskd_pkg.sv */
// Shared types, codes and decode functions for the sortable key decoder.
`timescale 1ns / 1ps

package bskd_pkg;

    localparam int MAX_COLUMNS_DEFAULT = 16;

    // Column type codes
    localparam logic [2:0] COL_BOOL   = 3'd0;
    localparam logic [2:0] COL_INT8   = 3'd1;
    localparam logic [2:0] COL_INT16  = 3'd2;
    localparam logic [2:0] COL_INT32  = 3'd3;
    localparam logic [2:0] COL_INT64  = 3'd4;
    localparam logic [2:0] COL_FP32   = 3'd5;
    localparam logic [2:0] COL_FP64   = 3'd6;
    localparam logic [2:0] COL_STRING = 3'd7;

    // Result kinds
    localparam logic [1:0] KIND_NULL     = 2'd0;
    localparam logic [1:0] KIND_SCALAR   = 2'd1;
    localparam logic [1:0] KIND_STR_BYTE = 2'd2;
    localparam logic [1:0] KIND_STR_END  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_COLUMN_COUNT = 1'b0;
    localparam logic CFG_COLUMN_TYPES = 1'b1;

    typedef struct packed {
        logic [3:0]  column;
        logic [1:0]  kind;
        logic [63:0] value;
        logic        last_field;
    } result_t;

    // Fixed field length minus one, in bytes
    function automatic logic [2:0] fixed_len_m1(input logic [2:0] t);
        logic [2:0] n;
        case (t)
            COL_INT16: n = 3'd1;
            COL_INT32: n = 3'd3;
            COL_INT64: n = 3'd7;
            COL_FP32:  n = 3'd3;
            COL_FP64:  n = 3'd7;
            default:   n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [63:0] decode_fixed(input logic [2:0] t, input logic [63:0] a);
        logic [63:0] v;
        logic [7:0]  b8;
        logic [15:0] b16;
        logic [31:0] b32;
        b8  = a[7:0] ^ 8'h80;
        b16 = a[15:0] ^ 16'h8000;
        b32 = a[31:0] ^ 32'h8000_0000;
        case (t)
            COL_BOOL:  v = (a[7:0] == 8'd1) ? 64'd0 : 64'd1;
            COL_INT8:  v = {{56{b8[7]}}, b8};
            COL_INT16: v = {{48{b16[15]}}, b16};
            COL_INT32: v = {{32{b32[31]}}, b32};
            COL_INT64: v = {~a[63], a[62:0]};
            COL_FP32:  v = a[31] ? {32'd0, b32} : {32'd0, ~a[31:0]};
            COL_FP64:  v = a[63] ? {1'b0, a[62:0]} : ~a;
            default:   v = a;
        endcase
        return v;
    endfunction

endpackage

/* hdl/binary_sortable_key_decoder_unit.sv */
// Top level: byte-serial decoder for order-preserving key records.
// A result is registered into the output stage when the byte that completes it is taken.
// Throughput: one byte per cycle while the skid entry is empty; column state updates in the cycle a byte is taken.
// A two-entry output stage (result register plus skid) keeps input flowing while
// the output stalls; input stalls only when both entries hold results.
// Reset clears configuration, parser state and output valid flags.
`timescale 1ns / 1ps

module binary_sortable_key_decoder_unit #(
    parameter int MAX_COLUMNS = bskd_pkg::MAX_COLUMNS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [47:0] cfg_data,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [3:0] column, [67:4] value, [71:68] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last_field
);

    localparam logic [4:0] MaxCol = 5'(MAX_COLUMNS);

    typedef enum logic [1:0] {
        PH_MARKER,
        PH_FIXED,
        PH_STRING,
        PH_ESCAPE
    } phase_t;

    logic [4:0]  column_count_reg;
    logic [47:0] column_types_reg;

    phase_t      phase_reg, phase_next;
    logic [4:0]  column_index_reg, column_index_next;
    logic [2:0]  byte_count_reg, byte_count_next;
    logic [63:0] accumulator_reg, accumulator_next;
    logic [31:0] string_length_reg, string_length_next;

    bskd_pkg::result_t out_reg, skid_reg, res;
    logic        out_valid_reg, skid_valid_reg;
    logic        res_valid;

    logic        in_beat, out_beat;
    logic [4:0]  col_limit;
    logic [2:0]  col_type;
    logic [5:0]  type_sel;
    logic [63:0] acc_shift;
    logic [31:0] len_inc;
    logic        is_final_col;
    logic [7:0]  b;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = !skid_valid_reg;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = m_axis_tvalid && m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.value, out_reg.column};
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_reg.last_field;

    assign b         = s_axis_tdata;
    assign col_limit = (column_count_reg > MaxCol) ? MaxCol : column_count_reg;
    assign type_sel  = 6'(column_index_reg[3:0]) * 6'd3;
    // columns past the register width read as bool
    assign col_type  = column_index_reg[4] ? bskd_pkg::COL_BOOL
                                           : column_types_reg[type_sel +: 3];
    assign acc_shift = {accumulator_reg[55:0], b};
    assign len_inc   = (string_length_reg == 32'hFFFF_FFFF) ? string_length_reg
                                                            : string_length_reg + 32'd1;
    assign is_final_col = (6'(column_index_reg) + 6'd1) == 6'(col_limit);

    always_comb
    begin
        phase_next         = phase_reg;
        column_index_next  = column_index_reg;
        byte_count_next    = byte_count_reg;
        accumulator_next   = accumulator_reg;
        string_length_next = string_length_reg;
        res_valid          = 1'b0;
        res.column         = column_index_reg[3:0];
        res.kind           = bskd_pkg::KIND_NULL;
        res.value          = 64'd0;
        res.last_field     = is_final_col;

        if (column_index_reg < col_limit)
        begin
            case (phase_reg)
                PH_MARKER:
                begin
                    if (b == 8'd0)
                    begin
                        res_valid          = 1'b1;
                        column_index_next  = column_index_reg + 5'd1;
                        byte_count_next    = 3'd0;
                        accumulator_next   = 64'd0;
                        string_length_next = 32'd0;
                    end
                    else if (col_type == bskd_pkg::COL_STRING)
                    begin
                        phase_next         = PH_STRING;
                        string_length_next = 32'd0;
                    end
                    else
                    begin
                        phase_next       = PH_FIXED;
                        accumulator_next = 64'd0;
                        byte_count_next  = bskd_pkg::fixed_len_m1(col_type);
                    end
                end
                PH_FIXED:
                begin
                    accumulator_next = acc_shift;
                    if (byte_count_reg == 3'd0)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = bskd_pkg::KIND_SCALAR;
                        res.value          = bskd_pkg::decode_fixed(col_type, acc_shift);
                        phase_next         = PH_MARKER;
                        column_index_next  = column_index_reg + 5'd1;
                        accumulator_next   = 64'd0;
                        string_length_next = 32'd0;
                    end
                    else
                    begin
                        byte_count_next = byte_count_reg - 3'd1;
                    end
                end
                PH_STRING:
                begin
                    if (b == 8'd0)
                    begin
                        res_valid          = 1'b1;
                        res.kind           = bskd_pkg::KIND_STR_END;
                        res.value          = {32'd0, string_length_reg};
                        phase_next         = PH_MARKER;
                        column_index_next  = column_index_reg + 5'd1;
                        byte_count_next    = 3'd0;
                        accumulator_next   = 64'd0;
                        string_length_next = 32'd0;
                    end
                    else if (b == 8'd1)
                    begin
                        phase_next = PH_ESCAPE;
                    end
                    else
                    begin
                        res_valid          = 1'b1;
                        res.kind           = bskd_pkg::KIND_STR_BYTE;
                        res.value          = {56'd0, b};
                        res.last_field     = 1'b0;
                        string_length_next = len_inc;
                    end
                end
                default:
                begin
                    // escaped byte, decremented with wrap
                    res_valid          = 1'b1;
                    res.kind           = bskd_pkg::KIND_STR_BYTE;
                    res.value          = {56'd0, b - 8'd1};
                    res.last_field     = 1'b0;
                    string_length_next = len_inc;
                    phase_next         = PH_STRING;
                end
            endcase
        end

        if (s_axis_tlast)
        begin
            phase_next         = PH_MARKER;
            column_index_next  = 5'd0;
            byte_count_next    = 3'd0;
            accumulator_next   = 64'd0;
            string_length_next = 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg  <= 5'd0;
            column_types_reg  <= 48'd0;
            phase_reg         <= PH_MARKER;
            column_index_reg  <= 5'd0;
            byte_count_reg    <= 3'd0;
            accumulator_reg   <= 64'd0;
            string_length_reg <= 32'd0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    bskd_pkg::CFG_COLUMN_COUNT: column_count_reg <= cfg_data[4:0];
                    bskd_pkg::CFG_COLUMN_TYPES: column_types_reg <= cfg_data;
                    default: ;
                endcase
            end

            if (in_beat)
            begin
                phase_reg         <= phase_next;
                column_index_reg  <= column_index_next;
                byte_count_reg    <= byte_count_next;
                accumulator_reg   <= accumulator_next;
                string_length_reg <= string_length_next;
            end

            if (skid_valid_reg)
            begin
                if (out_beat)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (in_beat && res_valid)
            begin
                if (!out_valid_reg || out_beat)
                    out_valid_reg <= 1'b1;
                else
                    skid_valid_reg <= 1'b1;
            end
            else if (out_beat)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_beat)
                out_reg <= skid_reg;
        end
        else if (in_beat && res_valid)
        begin
            if (!out_valid_reg || out_beat)
                out_reg <= res;
            else
                skid_reg <= res;
        end
    end

endmodule
